>>> src/bpt_pkg.sv
// Shared types and constants of the bracket pair table builder.
package bpt_pkg;

  localparam int unsigned MAX_LEN = 512;
  localparam int unsigned POS_W = 10;
  localparam int unsigned ERR_W = 2;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef logic [POS_W-1:0] pos_t;

  localparam logic [7:0] CH_SQ_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_SQ_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] CH_RD_OPEN  = 8'h28;  // (
  localparam logic [7:0] CH_RD_CLOSE = 8'h29;  // )
  localparam logic [7:0] CH_CUT      = 8'h7C;  // |

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVF   = 2'd2;

  localparam logic REC_PAIR = 1'b0;
  localparam logic REC_END  = 1'b1;

  localparam logic BRK_SQUARE = 1'b0;
  localparam logic BRK_ROUND  = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

  typedef struct packed {
    logic             record_kind;
    pos_t             open_pos;
    pos_t             close_pos;
    logic             bracket_kind;
    pos_t             cut_pos;
    logic [ERR_W-1:0] error_code;
    logic             last_out;
  } rec_t;

endpackage

>>> src/bpt_stack_cell.sv
// One cell of a shift stack: takes the upper neighbour on push, the lower on pop.
module bpt_stack_cell
  import bpt_pkg::*;
(
  input  logic      clk_i,
  input  stk_ctrl_t ctrl_i,
  input  pos_t      from_up_i,
  input  pos_t      from_down_i,
  output pos_t      value_o
);

  pos_t value_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      value_q <= from_up_i;
    end else if (ctrl_i.pop) begin
      value_q <= from_down_i;
    end
  end

  assign value_o = value_q;

endmodule

>>> src/bpt_stack.sv
// Position stack built as a row of shift cells, top of stack in cell zero.
module bpt_stack
  import bpt_pkg::*;
#(
  parameter int unsigned Depth = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stk_ctrl_t ctrl_i,
  input  pos_t      push_data_i,
  output pos_t      top_data_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [CntW-1:0] count_q, count_d;
  stk_ctrl_t       cell_ctrl;
  pos_t            cell_val [Depth];

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));

  always_comb begin
    cell_ctrl.push  = ctrl_i.push && !full_o;
    cell_ctrl.pop   = ctrl_i.pop && !empty_o && !cell_ctrl.push;
    cell_ctrl.clear = ctrl_i.clear;
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (cell_ctrl.push) begin
      count_d = count_q + CntW'(1);
    end else if (cell_ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    pos_t up_val;
    pos_t down_val;
    if (i == 0) begin : g_head
      assign up_val = push_data_i;
    end else begin : g_body
      assign up_val = cell_val[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign down_val = '0;
    end else begin : g_inner
      assign down_val = cell_val[i+1];
    end
    bpt_stack_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .from_up_i   (up_val),
      .from_down_i (down_val),
      .value_o     (cell_val[i])
    );
  end

  assign top_data_o = cell_val[0];

endmodule

>>> src/bpt_rec_fifo.sv
// Small record queue taking up to two records a cycle and giving out one when the reader is ready.
module bpt_rec_fifo
  import bpt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr0_i,
  input  rec_t data0_i,
  input  logic wr1_i,
  input  rec_t data1_i,
  output logic room2_o,
  output logic valid_o,
  input  logic ready_i,
  output rec_t data_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  rec_t            mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [CntW-1:0] count_q;
  logic            rd;

  assign wr_ptr1  = wr_ptr_q + PtrW'(1);
  assign valid_o  = (count_q != '0);
  assign rd       = valid_o && ready_i;
  assign room2_o  = (count_q <= CntW'(FIFO_DEPTH - 2));
  assign data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (wr1_i) begin
      mem_q[wr_ptr1] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(wr0_i) + PtrW'(wr1_i);
      rd_ptr_q <= rd_ptr_q + PtrW'(rd);
      count_q  <= count_q + CntW'(wr0_i) + CntW'(wr1_i) - CntW'(rd);
    end
  end

endmodule

>>> src/bracket_pair_table_builder.sv
// Top level of the bracket pair table builder.
// Takes one character per cycle and counts 1-based positions itself. Each
// bracket kind has its own stack, a row of MAX_LEN shift cells with the top
// in the first cell, so a push or pop completes in the cycle the character
// is accepted. Records are registered in a four-entry queue, from which the
// master side reads them; s_axis_tready is high while the queue has at
// least two free entries. With the master side taking a record every
// cycle, input is taken every cycle while each character gives at most one
// record; a closing bracket that ends its string gives two, and a run of
// those cannot be taken every cycle, since the queue fills faster than it
// drains. No clearing pass follows reset.
module bracket_pair_table_builder
  import bpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // include_round
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,     // symbol
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,     // open_pos, close_pos, bracket_kind, cut_pos, error_code
  output logic        m_axis_tuser,     // record_kind
  output logic        m_axis_tlast      // last_out
);

  localparam int unsigned PosW = $clog2(MAX_LEN + 2);

  logic            incl_round_q;
  logic [PosW-1:0] pos_q, pos_d, pos_n;
  logic [PosW-1:0] cut_q, cut_d;
  logic [ERR_W-1:0] err_q, err_d, err_now;
  logic            accept, in_range;
  logic            sq_open, sq_close, rd_open, rd_close, is_cut;
  stk_ctrl_t       sq_ctrl, rd_ctrl;
  pos_t            sq_top, rd_top;
  logic            sq_empty, sq_full, rd_empty, rd_full;
  logic            pair, pair_empty;
  rec_t            pair_rec, end_rec, rec0;
  logic            room2;
  rec_t            out_rec;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room2;
  assign in_range = (pos_q < PosW'(MAX_LEN));
  assign pos_n    = pos_q + PosW'(1);

  assign sq_open  = in_range && (s_axis_tdata == CH_SQ_OPEN);
  assign sq_close = in_range && (s_axis_tdata == CH_SQ_CLOSE);
  assign rd_open  = in_range && incl_round_q && (s_axis_tdata == CH_RD_OPEN);
  assign rd_close = in_range && incl_round_q && (s_axis_tdata == CH_RD_CLOSE);
  assign is_cut   = in_range && (s_axis_tdata == CH_CUT);

  assign sq_ctrl.push  = accept && sq_open;
  assign sq_ctrl.pop   = accept && sq_close;
  assign sq_ctrl.clear = accept && s_axis_tlast;
  assign rd_ctrl.push  = accept && rd_open;
  assign rd_ctrl.pop   = accept && rd_close;
  assign rd_ctrl.clear = accept && s_axis_tlast;

  bpt_stack #(.Depth(MAX_LEN)) u_sq_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sq_ctrl),
    .push_data_i (POS_W'(pos_n)),
    .top_data_o  (sq_top),
    .empty_o     (sq_empty),
    .full_o      (sq_full)
  );

  bpt_stack #(.Depth(MAX_LEN)) u_rd_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rd_ctrl),
    .push_data_i (POS_W'(pos_n)),
    .top_data_o  (rd_top),
    .empty_o     (rd_empty),
    .full_o      (rd_full)
  );

  assign pair       = sq_close || rd_close;
  assign pair_empty = sq_close ? sq_empty : rd_empty;

  always_comb begin
    err_now = err_q;
    if (err_q == ERR_NONE) begin
      if (!in_range || (sq_open && sq_full) || (rd_open && rd_full)) begin
        err_now = ERR_OVF;
      end else if (pair && pair_empty) begin
        err_now = ERR_EMPTY;
      end
    end

    cut_d = cut_q;
    if (is_cut && (cut_q == '0)) begin
      cut_d = pos_n;
    end

    pair_rec.record_kind  = REC_PAIR;
    pair_rec.open_pos     = pair_empty ? '0 : (sq_close ? sq_top : rd_top);
    pair_rec.close_pos    = POS_W'(pos_n);
    pair_rec.bracket_kind = sq_close ? BRK_SQUARE : BRK_ROUND;
    pair_rec.cut_pos      = '0;
    pair_rec.error_code   = pair_empty ? ERR_EMPTY : ERR_NONE;
    pair_rec.last_out     = 1'b0;

    end_rec.record_kind  = REC_END;
    end_rec.open_pos     = '0;
    end_rec.close_pos    = '0;
    end_rec.bracket_kind = BRK_SQUARE;
    end_rec.cut_pos      = POS_W'(cut_d);
    end_rec.error_code   = err_now;
    end_rec.last_out     = 1'b1;

    rec0 = pair ? pair_rec : end_rec;

    pos_d = in_range ? pos_n : PosW'(MAX_LEN + 1);
    err_d = err_now;
    if (s_axis_tlast) begin
      pos_d = '0;
      cut_d = '0;
      err_d = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_round_q <= 1'b1;
      pos_q        <= '0;
      cut_q        <= '0;
      err_q        <= ERR_NONE;
    end else begin
      if (cfg_we_i) begin
        incl_round_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q <= pos_d;
        cut_q <= cut_d;
        err_q <= err_d;
      end
    end
  end

  bpt_rec_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr0_i    (accept && (pair || s_axis_tlast)),
    .data0_i  (rec0),
    .wr1_i    (accept && pair && s_axis_tlast),
    .data1_i  (end_rec),
    .room2_o  (room2),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (out_rec)
  );

  assign m_axis_tdata = {7'd0, out_rec.error_code, out_rec.cut_pos, out_rec.bracket_kind,
                         out_rec.close_pos, out_rec.open_pos};
  assign m_axis_tuser = out_rec.record_kind;
  assign m_axis_tlast = out_rec.last_out;

endmodule

>>> tb/bracket_pair_table_builder_checker.sv
// Checker for the bracket pair table builder: predicts records from requests and compares them.
`timescale 1ns / 1ps

module bracket_pair_table_builder_checker
  import bpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  logic             round_on;
  pos_t             position;
  pos_t             sq_stack [MAX_LEN];
  pos_t             rd_stack [MAX_LEN];
  int               sq_top;
  int               rd_top;
  pos_t             cut_seen;
  logic [ERR_W-1:0] err_seen;
  rec_t             records_due [$];

  task automatic note_error(input logic [ERR_W-1:0] code);
    if (err_seen == ERR_NONE) begin
      err_seen = code;
    end
  endtask

  task automatic push_open(input logic kind);
    if (kind == BRK_ROUND) begin
      if (rd_top >= MAX_LEN) begin
        note_error(ERR_OVF);
      end else begin
        rd_stack[rd_top] = position;
        rd_top++;
      end
    end else begin
      if (sq_top >= MAX_LEN) begin
        note_error(ERR_OVF);
      end else begin
        sq_stack[sq_top] = position;
        sq_top++;
      end
    end
  endtask

  task automatic close_pair(input logic kind);
    rec_t r;
    r = '0;
    r.record_kind  = REC_PAIR;
    r.close_pos    = position;
    r.bracket_kind = kind;
    if ((kind == BRK_ROUND ? rd_top : sq_top) == 0) begin
      note_error(ERR_EMPTY);
      r.error_code = ERR_EMPTY;
    end else if (kind == BRK_ROUND) begin
      rd_top--;
      r.open_pos = rd_stack[rd_top];
    end else begin
      sq_top--;
      r.open_pos = sq_stack[sq_top];
    end
    records_due.push_back(r);
  endtask

  task automatic build_records(input logic [7:0] sym, input logic lst);
    rec_t r;
    if (position < MAX_LEN) begin
      position = position + 1'b1;
      if (sym == CH_SQ_OPEN) begin
        push_open(BRK_SQUARE);
      end else if (sym == CH_SQ_CLOSE) begin
        close_pair(BRK_SQUARE);
      end else if (sym == CH_RD_OPEN && round_on) begin
        push_open(BRK_ROUND);
      end else if (sym == CH_RD_CLOSE && round_on) begin
        close_pair(BRK_ROUND);
      end else if (sym == CH_CUT) begin
        if (cut_seen == '0) begin
          cut_seen = position;
        end
      end
    end else begin
      position = POS_W'(MAX_LEN + 1);
      note_error(ERR_OVF);
    end
    if (lst) begin
      r = '0;
      r.record_kind = REC_END;
      r.cut_pos     = cut_seen;
      r.error_code  = err_seen;
      r.last_out    = 1'b1;
      records_due.push_back(r);
      position = '0;
      sq_top   = 0;
      rd_top   = 0;
      cut_seen = '0;
      err_seen = ERR_NONE;
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_record();
    rec_t want;
    if (records_due.size() == 0) begin
      $error("record with none due: tdata %h tuser %b tlast %b",
             m_axis_tdata, m_axis_tuser, m_axis_tlast);
      fail_count_o++;
    end else begin
      want = records_due.pop_front();
      compare_field("record_kind", want.record_kind, m_axis_tuser);
      compare_field("open_pos", want.open_pos, m_axis_tdata[9:0]);
      compare_field("close_pos", want.close_pos, m_axis_tdata[19:10]);
      compare_field("bracket_kind", want.bracket_kind, m_axis_tdata[20]);
      compare_field("cut_pos", want.cut_pos, m_axis_tdata[30:21]);
      compare_field("error_code", want.error_code, m_axis_tdata[32:31]);
      compare_field("last_out", want.last_out, m_axis_tlast);
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_on = 1'b1;
      position = '0;
      sq_top   = 0;
      rd_top   = 0;
      cut_seen = '0;
      err_seen = ERR_NONE;
      records_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        build_records(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_record();
      end
      if (cfg_we_i) begin
        round_on = cfg_wdata_i;
      end
    end
    pending_o = records_due.size();
  end

endmodule

>>> tb/bracket_pair_table_builder_tb.sv
// Testbench top of the bracket pair table builder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module bracket_pair_table_builder_tb;
  import bpt_pkg::*;

  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam int         STALL_LIMIT = 1000;
  localparam int         PHASE_ITEMS = 180;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;

  logic        quiet;
  int          stall_cycles;
  int          phase_items;
  logic [7:0]  line_buf [$];
  logic        open_q [$];

  bracket_pair_table_builder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  bracket_pair_table_builder_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready = quiet || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_mark();
    case ($urandom_range(0, 5))
      0:       pick_mark = CH_SQ_OPEN;
      1:       pick_mark = CH_SQ_CLOSE;
      2:       pick_mark = CH_RD_OPEN;
      3:       pick_mark = CH_RD_CLOSE;
      4:       pick_mark = CH_CUT;
      default: pick_mark = CH_DOT;
    endcase
  endfunction

  function automatic logic [7:0] pick_filler();
    case ($urandom_range(0, 3))
      0:       pick_filler = CH_CUT;
      1:       pick_filler = 8'($urandom_range(8'h41, 8'h5A));
      2:       pick_filler = 8'($urandom_range(8'h61, 8'h7A));
      default: pick_filler = CH_DOT;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] sym, input logic lst);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = sym;
    s_axis_tlast  = lst;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      send_item(line_buf[i], i == line_buf.size() - 1);
    end
    phase_items += line_buf.size();
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1);
    end
  endtask

  task automatic write_round(input logic v);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic make_short_line();
    int style;
    int len;
    int remaining;
    int pick;
    style = $urandom_range(0, 99);
    len   = $urandom_range(1, 24);
    open_q.delete();
    if (style < 75) begin
      for (int i = 0; i < len; i++) begin
        remaining = len - i;
        pick = $urandom_range(0, 2);
        if (open_q.size() > 0 && (open_q.size() >= remaining || pick == 1)) begin
          line_buf.push_back(open_q.pop_back() ? CH_RD_CLOSE : CH_SQ_CLOSE);
        end else if (pick == 0 && open_q.size() + 1 <= remaining - 1) begin
          open_q.push_back(1'($urandom_range(0, 1)));
          line_buf.push_back(open_q[$] ? CH_RD_OPEN : CH_SQ_OPEN);
        end else begin
          line_buf.push_back(pick_filler());
        end
      end
      // break a fifth of the well-formed lines
      if (style >= 60) begin
        pick = $urandom_range(0, len - 1);
        line_buf[pick] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_mark();
      end
    end else begin
      for (int i = 0; i < len; i++) begin
        line_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_mark());
      end
    end
  endtask

  initial begin
    quiet         = 1'b0;
    stall_cycles  = 0;
    phase_items   = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    write_round(1'b1);
    send_text("[]");
    send_text("]");
    send_text("([|)]|");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("a)");
    write_round(1'b0);
    send_text("(](|)");
    send_text("[(])");
    write_round(1'b1);
    send_text("(");

    for (int ph = 0; ph < 7; ph++) begin
      write_round(ph == 0 ? 1'b0 : (ph == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
      quiet       = (ph == 3);
      phase_items = 0;
      if (ph == 1) begin
        // deep nesting, then run past the length limit
        open_q.delete();
        for (int i = 0; i < 256; i++) begin
          open_q.push_back(1'($urandom_range(0, 1)));
          line_buf.push_back(open_q[$] ? CH_RD_OPEN : CH_SQ_OPEN);
        end
        while (open_q.size() > 0) begin
          line_buf.push_back(open_q.pop_back() ? CH_RD_CLOSE : CH_SQ_CLOSE);
        end
        repeat (8) line_buf.push_back(pick_mark());
        send_line();
      end
      while (phase_items < PHASE_ITEMS) begin
        make_short_line();
        send_line();
      end
    end
    quiet = 1'b0;

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
